// File: hw/rtl/rpws_pkg.sv
// ----------------------------------------------------------------------------
// rpws_pkg
// Shared types and constants for the RC pulse width to stick block.
// ----------------------------------------------------------------------------
package rpws_pkg;

	localparam int NumCh   = 4;
	localparam int ChW     = 2;
	localparam int TsW     = 16;
	localparam int StickW  = 8;
	localparam int MaxW    = 7;
	localparam int AddrW   = 4;
	localparam int DataW   = 32;

	localparam logic [ChW-1:0] ThrottleCh = 2'd2;

	// register indexes, paddr[3:2]
	localparam logic [1:0] RegNeutral  = 2'd0;
	localparam logic [1:0] RegLow      = 2'd1;
	localparam logic [1:0] RegStickMax = 2'd2;
	localparam logic [1:0] RegStickMin = 2'd3;

	localparam logic [TsW-1:0]    NeutralRst  = 16'd1500;
	localparam logic [TsW-1:0]    LowRst      = 16'd900;
	localparam logic [MaxW-1:0]   StickMaxRst = 7'd125;
	localparam logic [StickW-1:0] StickMinRst = 8'h83;

	typedef struct packed {
		logic [TsW-1:0]           neutral_width;
		logic [TsW-1:0]           low_width;
		logic [MaxW-1:0]          stick_max;
		logic signed [StickW-1:0] stick_min;
	} cfg_t;

endpackage

// File: hw/rtl/rpws_evt_if.sv
// ----------------------------------------------------------------------------
// rpws_evt_if
// Edge event channel: channel number, edge direction and timer stamp.
// ----------------------------------------------------------------------------
interface rpws_evt_if;
	logic                      valid;
	logic                      ready;
	logic [rpws_pkg::ChW-1:0]  channel;
	logic                      edge_rising;
	logic [rpws_pkg::TsW-1:0]  timestamp;

	modport source (output valid, output channel, output edge_rising, output timestamp,
		input ready);
	modport sink (input valid, input channel, input edge_rising, input timestamp,
		output ready);
endinterface

// File: hw/rtl/rpws_res_if.sv
// ----------------------------------------------------------------------------
// rpws_res_if
// Result channel: measured pulse width, stick value and seen mask.
// ----------------------------------------------------------------------------
interface rpws_res_if;
	logic                               valid;
	logic                               ready;
	logic [rpws_pkg::ChW-1:0]           out_channel;
	logic [rpws_pkg::TsW-1:0]           pulse_width;
	logic signed [rpws_pkg::StickW-1:0] stick_value;
	logic [rpws_pkg::NumCh-1:0]         seen_mask;

	modport source (output valid, output out_channel, output pulse_width,
		output stick_value, output seen_mask, input ready);
	modport sink (input valid, input out_channel, input pulse_width,
		input stick_value, input seen_mask, output ready);
endinterface

// File: hw/rtl/rc_pulse_width_to_stick.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_to_stick
// Four-channel RC receiver pulse capture with stick scaling and clamping.
// ----------------------------------------------------------------------------
// One edge event is accepted every clock while the output register is empty
// or its result is taken. A rising edge writes its stamp into the four-entry
// start-stamp memory; a falling edge reads the stored start in the accept cycle
// and carries its result through the memory read register, the width/difference
// stage and the scale/clamp output register. The memory is written by rising
// edges and read by every accepted event. Entries never written since reset
// read as zero through per-entry valid flags, so no clearing pass is needed.
// Rising edges give no result. Configuration is to be written over APB while
// no events are in flight; the block itself does not enforce this.
module rc_pulse_width_to_stick (
	input  logic                       clk,
	input  logic                       arst_n,
	rpws_evt_if.sink                   evt,
	rpws_res_if.source                 res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rpws_pkg::AddrW-1:0] paddr,
	input  logic [rpws_pkg::DataW-1:0] pwdata,
	output logic [rpws_pkg::DataW-1:0] prdata,
	output logic                       pready
);
	import rpws_pkg::*;

	localparam int DiffW = TsW + 1;

	cfg_t cfg;

	rpws_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [TsW-1:0]   start_mem [NumCh];
	logic [NumCh-1:0] start_vld_q;
	logic [NumCh-1:0] mask_q;
	logic [NumCh-1:0] mask_nxt;

	logic advance;
	logic accept;

	// stage 1
	logic             vld_s1;
	logic [ChW-1:0]   ch_s1;
	logic [TsW-1:0]   ts_s1;
	logic [NumCh-1:0] mask_s1;
	logic [TsW-1:0]   start_s1;
	logic             start_vld_s1;

	// stage 2
	logic                    vld_s2;
	logic [ChW-1:0]          ch_s2;
	logic [TsW-1:0]          width_s2;
	logic signed [DiffW-1:0] diff_s2;
	logic [NumCh-1:0]        mask_s2;

	// output register
	logic                     out_vld_q;
	logic [ChW-1:0]           out_ch_q;
	logic [TsW-1:0]           out_width_q;
	logic signed [StickW-1:0] out_stick_q;
	logic [NumCh-1:0]         out_mask_q;

	logic [TsW-1:0]          start_eff;
	logic [TsW-1:0]          width;
	logic [TsW-1:0]          ref_width;
	logic signed [DiffW-1:0] diff;
	logic                    thr_s2;
	logic signed [DiffW-1:0] quot;
	logic signed [DiffW-1:0] hi;
	logic signed [DiffW-1:0] lo;
	logic signed [StickW-1:0] stick;

	assign advance   = !out_vld_q || res.ready;
	assign evt.ready = advance;
	assign accept    = evt.valid && evt.ready;
	assign mask_nxt  = mask_q | (NumCh'(1) << evt.channel);

	// start-stamp memory: rising edges write, every accepted event reads
	always_ff @(posedge clk) begin
		if (accept && evt.edge_rising)
			start_mem[evt.channel] <= evt.timestamp;
		if (accept)
			start_s1 <= start_mem[evt.channel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_vld_q <= '0;
			mask_q      <= '0;
		end else if (accept) begin
			mask_q <= mask_nxt;
			if (evt.edge_rising)
				start_vld_q[evt.channel] <= 1'b1;
		end
	end

	// stage 1: carries only falling edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= accept && !evt.edge_rising;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1        <= evt.channel;
			ts_s1        <= evt.timestamp;
			mask_s1      <= mask_nxt;
			start_vld_s1 <= start_vld_q[evt.channel];
		end
	end

	always_comb begin
		start_eff = start_vld_s1 ? start_s1 : '0;
		width     = ts_s1 - start_eff;
		ref_width = (ch_s1 == ThrottleCh) ? cfg.low_width : cfg.neutral_width;
		diff      = $signed({1'b0, width}) - $signed({1'b0, ref_width});
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s2    <= ch_s1;
			width_s2 <= width;
			diff_s2  <= diff;
			mask_s2  <= mask_s1;
		end
	end

	// scale with truncation toward zero, then clamp (upper bound first)
	always_comb begin
		thr_s2 = (ch_s2 == ThrottleCh);
		hi     = $signed({{(DiffW-MaxW){1'b0}}, cfg.stick_max});
		lo     = DiffW'(cfg.stick_min);
		if (thr_s2)
			quot = diff_s2 >>> 3;
		else if (diff_s2 < 0)
			quot = (diff_s2 + DiffW'(3)) >>> 2;
		else
			quot = diff_s2 >>> 2;

		if (thr_s2 && diff_s2 <= 0)
			stick = '0;
		else if (quot > hi)
			stick = hi[StickW-1:0];
		else if (quot < lo)
			stick = lo[StickW-1:0];
		else
			stick = quot[StickW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_ch_q    <= ch_s2;
			out_width_q <= width_s2;
			out_stick_q <= stick;
			out_mask_q  <= mask_s2;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.out_channel = out_ch_q;
	assign res.pulse_width = out_width_q;
	assign res.stick_value = out_stick_q;
	assign res.seen_mask   = out_mask_q;

	// a result always reports its own channel as seen
	a_seen_own: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.seen_mask[res.out_channel])
		else $error("result channel missing from seen mask");

	// throttle stick never goes negative
	a_thr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.out_channel == ThrottleCh) |-> !res.stick_value[StickW-1])
		else $error("negative throttle stick value");

	// seen mask is sticky
	a_mask_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((mask_q & $past(mask_q)) == $past(mask_q)))
		else $error("seen mask lost a bit");

	// an empty output register never blocks input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> evt.ready)
		else $error("input stalled with empty output register");

endmodule

// File: hw/rtl/rpws_cfg.sv
// ----------------------------------------------------------------------------
// rpws_cfg
// APB register file: neutral width, low width and the two stick clamps.
// ----------------------------------------------------------------------------
module rpws_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpws_pkg::AddrW-1:0]  paddr,
	input  logic [rpws_pkg::DataW-1:0]  pwdata,
	output logic [rpws_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output rpws_pkg::cfg_t              cfg
);
	import rpws_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[AddrW-1:2];
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral_width <= NeutralRst;
			cfg_q.low_width     <= LowRst;
			cfg_q.stick_max     <= StickMaxRst;
			cfg_q.stick_min     <= StickMinRst;
		end else if (wr_en) begin
			case (idx)
				RegNeutral:  cfg_q.neutral_width <= pwdata[TsW-1:0];
				RegLow:      cfg_q.low_width     <= pwdata[TsW-1:0];
				RegStickMax: cfg_q.stick_max     <= pwdata[MaxW-1:0];
				RegStickMin: cfg_q.stick_min     <= pwdata[StickW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RegNeutral:  prdata = {{(DataW-TsW){1'b0}}, cfg_q.neutral_width};
			RegLow:      prdata = {{(DataW-TsW){1'b0}}, cfg_q.low_width};
			RegStickMax: prdata = {{(DataW-MaxW){1'b0}}, cfg_q.stick_max};
			RegStickMin: prdata = {{(DataW-StickW){1'b0}}, cfg_q.stick_min};
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
